// ===== sv/qfd_pkg.sv =====
`timescale 1ns / 1ps

package qfd_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int AMOUNT_BITS_DEF = 16;

    localparam logic REQ_PRODUCE = 1'b0;
    localparam logic REQ_CONSUME = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_READ_LAST,
        ST_LOAD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic step;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_consume;
        logic drain_done;
        logic out_busy;
    } t_status;

endpackage

// ===== sv/qfd_ctrl.sv =====
`timescale 1ns / 1ps

module qfd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  qfd_pkg::t_status i_status,
    output qfd_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    qfd_pkg::t_state r_state;
    qfd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qfd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            qfd_pkg::ST_IDLE: begin
                if (i_valid) begin
                    // the request type is sampled straight from the port
                    n_state = qfd_pkg::ST_READ_LAST;
                end
            end
            qfd_pkg::ST_READ: begin
                n_state = qfd_pkg::ST_DRAIN;
            end
            qfd_pkg::ST_DRAIN: begin
                n_state = i_status.drain_done ? qfd_pkg::ST_READ_LAST : qfd_pkg::ST_READ;
            end
            qfd_pkg::ST_READ_LAST: begin
                n_state = qfd_pkg::ST_LOAD;
            end
            qfd_pkg::ST_LOAD: begin
                if (!i_status.out_busy) begin
                    n_state = qfd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = qfd_pkg::ST_IDLE;
            end
        endcase
        if (r_state == qfd_pkg::ST_IDLE && i_valid && i_status.is_consume) begin
            n_state = qfd_pkg::ST_READ;
        end
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            qfd_pkg::ST_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_valid;
            end
            qfd_pkg::ST_DRAIN: begin
                o_cmd.step = 1'b1;
            end
            qfd_pkg::ST_LOAD: begin
                o_cmd.load_out = !i_status.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/qfd_datapath.sv =====
`timescale 1ns / 1ps

module qfd_datapath #(
    parameter int DEPTH       = qfd_pkg::DEPTH_DEF,
    parameter int AMOUNT_BITS = qfd_pkg::AMOUNT_BITS_DEF,
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  qfd_pkg::t_cmd          i_cmd,
    output qfd_pkg::t_status       o_status,
    input  logic                   i_req_type,
    input  logic [AMOUNT_BITS-1:0] i_amount,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic [CNT_W-1:0]       o_occupancy,
    output logic [AMOUNT_BITS-1:0] o_oldest_amount,
    output logic [AMOUNT_BITS-1:0] o_unserved,
    output logic                   o_dropped
);

    logic [AMOUNT_BITS-1:0] r_mem [DEPTH];
    logic [AMOUNT_BITS-1:0] r_rd_data;
    logic [PTR_W-1:0]       r_oldest_ptr;
    logic [PTR_W-1:0]       r_newest_ptr;
    logic [CNT_W-1:0]       r_count;
    logic [AMOUNT_BITS-1:0] r_left;
    logic                   r_drop_pend;

    logic                   r_out_valid;
    logic [CNT_W-1:0]       r_occ;
    logic [AMOUNT_BITS-1:0] r_oldest_amt;
    logic [AMOUNT_BITS-1:0] r_unserved;
    logic                   r_dropped;

    logic                   w_full;
    logic                   w_empty;
    logic                   w_produce;
    logic                   w_covers;
    logic [PTR_W-1:0]       w_oldest_inc;
    logic [PTR_W-1:0]       w_newest_inc;
    logic                   w_wr_en;
    logic [PTR_W-1:0]       w_wr_addr;
    logic [AMOUNT_BITS-1:0] w_wr_data;

    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_produce = i_cmd.accept && (i_req_type == qfd_pkg::REQ_PRODUCE);
    assign w_covers  = (r_rd_data <= r_left);

    assign w_oldest_inc = (r_oldest_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_oldest_ptr + 1'b1;
    assign w_newest_inc = (r_newest_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_newest_ptr + 1'b1;

    // single write port: append on produce, in-place reduction on a partial drain
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_newest_ptr;
        w_wr_data = i_amount;
        if (w_produce && !w_full) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.step && !w_empty && !w_covers) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_oldest_ptr;
            w_wr_data = r_rd_data - r_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[r_oldest_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest_ptr <= '0;
            r_newest_ptr <= '0;
            r_count      <= '0;
        end else begin
            if (w_produce && !w_full) begin
                r_newest_ptr <= w_newest_inc;
                r_count      <= r_count + 1'b1;
            end else if (i_cmd.step && !w_empty && w_covers) begin
                r_oldest_ptr <= w_oldest_inc;
                r_count      <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_left      <= (i_req_type == qfd_pkg::REQ_CONSUME) ? i_amount : '0;
            r_drop_pend <= w_produce && w_full;
        end else if (i_cmd.step && !w_empty) begin
            r_left <= w_covers ? (r_left - r_rd_data) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_occ        <= r_count;
            r_oldest_amt <= w_empty ? '0 : r_rd_data;
            r_unserved   <= r_left;
            r_dropped    <= r_drop_pend;
        end
    end

    // drain stops on empty queue, exact or partial cover, or last entry taken
    assign o_status.is_consume = (i_req_type == qfd_pkg::REQ_CONSUME);
    assign o_status.drain_done = w_empty || (r_rd_data >= r_left) || (r_count == CNT_W'(1));
    assign o_status.out_busy   = r_out_valid && i_stall;

    assign o_valid         = r_out_valid;
    assign o_occupancy     = r_occ;
    assign o_oldest_amount = r_oldest_amt;
    assign o_unserved      = r_unserved;
    assign o_dropped       = r_dropped;

endmodule

// ===== sv/quantity_fifo_drain.sv =====
// Produce: after acceptance the block passes its read-last state, then its load state,
// which registers the result. Consume: the block passes a read and a drain state for
// each of k entries touched (k >= 1, an empty queue counts as one), then read-last and load.
// Each entry costs one registered memory read and one update in the drain state.
// A stalled result holds the block in its load state; a new request is taken only in idle.
// Reset (synchronous, active low) empties the queue and clears the output valid.
`timescale 1ns / 1ps

module quantity_fifo_drain #(
    parameter int DEPTH       = qfd_pkg::DEPTH_DEF,
    parameter int AMOUNT_BITS = qfd_pkg::AMOUNT_BITS_DEF,
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_req_type,
    input  logic [AMOUNT_BITS-1:0] i_amount,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [CNT_W-1:0]       o_occupancy,
    output logic [AMOUNT_BITS-1:0] o_oldest_amount,
    output logic [AMOUNT_BITS-1:0] o_unserved,
    output logic                   o_dropped
);

    qfd_pkg::t_cmd    w_cmd;
    qfd_pkg::t_status w_status;

    qfd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (o_stall)
    );

    qfd_datapath #(
        .DEPTH       (DEPTH),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_req_type      (i_req_type),
        .i_amount        (i_amount),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_occupancy     (o_occupancy),
        .o_oldest_amount (o_oldest_amount),
        .o_unserved      (o_unserved),
        .o_dropped       (o_dropped)
    );

endmodule

// ===== sv/qfd_checker.sv =====
`timescale 1ns / 1ps

module qfd_checker #(
    parameter int DEPTH       = qfd_pkg::DEPTH_DEF,
    parameter int AMOUNT_BITS = qfd_pkg::AMOUNT_BITS_DEF,
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [CNT_W-1:0]       o_occupancy,
    input logic [AMOUNT_BITS-1:0] o_oldest_amount,
    input logic [AMOUNT_BITS-1:0] o_unserved,
    input logic                   o_dropped
);

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_occupancy <= CNT_W'(DEPTH)))
        else $error("occupancy above depth");

    a_empty_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_occupancy == '0) |-> (o_oldest_amount == '0))
        else $error("empty queue shows nonzero oldest amount");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> (o_unserved == '0 && o_occupancy == CNT_W'(DEPTH)))
        else $error("drop flagged without full queue");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second transaction taken while first in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_occupancy) && $stable(o_unserved)))
        else $error("stalled result changed");

endmodule

bind quantity_fifo_drain qfd_checker #(
    .DEPTH       (DEPTH),
    .AMOUNT_BITS (AMOUNT_BITS)
) u_qfd_checker (.*);

// ===== dv/tb_quantity_fifo_drain.sv =====
`timescale 1ns / 1ps

module tb_quantity_fifo_drain;

    localparam int DEPTH       = qfd_pkg::DEPTH_DEF;
    localparam int AW          = qfd_pkg::AMOUNT_BITS_DEF;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 150;

    typedef struct {
        logic          kind;
        logic [AW-1:0] amount;
        bit            sync;    // wait for all results before offering
        bit            idle;    // random gaps on both sides around this one
    } t_request;

    typedef struct {
        logic [CNT_W-1:0] occupancy;
        logic [AW-1:0]    oldest_amount;
        logic [AW-1:0]    unserved;
        logic             dropped;
    } t_queue_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic             i_req_type = qfd_pkg::REQ_PRODUCE;
    logic [AW-1:0]    i_amount = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [CNT_W-1:0] o_occupancy;
    logic [AW-1:0]    o_oldest_amount;
    logic [AW-1:0]    o_unserved;
    logic             o_dropped;

    // shadow of the queue
    logic [AW-1:0] slot_amt [DEPTH];
    int unsigned   head_slot = 0;
    int unsigned   tail_slot = 0;
    int unsigned   held = 0;

    t_request      pending_q[$];
    t_queue_result expected_q[$];

    t_request    drv_cur;
    bit          drv_loaded = 1'b0;
    int          drv_gap = 0;
    bit          in_taken = 1'b0;
    bit          out_taken = 1'b0;
    bit          sink_idle = 1'b0;
    int          sink_wait = 0;
    bit          hold_on = 1'b0;
    int          err_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned cycle_cnt = 0;

    quantity_fifo_drain #(
        .DEPTH       (DEPTH),
        .AMOUNT_BITS (AW)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_amount        (i_amount),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_occupancy     (o_occupancy),
        .o_oldest_amount (o_oldest_amount),
        .o_unserved      (o_unserved),
        .o_dropped       (o_dropped)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_queue_result apply_request(logic kind, logic [AW-1:0] amt);
        t_queue_result r;
        logic [AW-1:0] left;
        logic [AW-1:0] x;
        bit            done;
        r = '{default: '0};
        left = amt;
        done = 1'b0;
        if (kind == qfd_pkg::REQ_PRODUCE) begin
            if (held >= DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                slot_amt[tail_slot] = amt;
                tail_slot = (tail_slot + 1) % DEPTH;
                held++;
            end
        end else begin
            // drain from the oldest entry; stop once the quantity is used up or the queue is empty
            while (!done && held > 0) begin
                x = slot_amt[head_slot];
                if (x <= left) begin
                    left = left - x;
                    head_slot = (head_slot + 1) % DEPTH;
                    held--;
                    if (left == 0) done = 1'b1;
                end else begin
                    slot_amt[head_slot] = x - left;
                    left = '0;
                    done = 1'b1;
                end
            end
            r.unserved = left;
        end
        r.occupancy = held[CNT_W-1:0];
        r.oldest_amount = (held > 0) ? slot_amt[head_slot] : '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s mismatch: got %0d expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    task automatic add_request(logic kind, logic [AW-1:0] amt, bit sync, bit idle);
        t_request t;
        t.kind = kind;
        t.amount = amt;
        t.sync = sync;
        t.idle = idle;
        pending_q.push_back(t);
    endtask

    // monitor: prediction on input transactions, checking on output transactions
    always @(posedge i_clk) begin
        t_queue_result want;
        cycle_cnt++;
        in_taken <= i_rst_n && i_valid && !o_stall;
        out_taken <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_q.push_back(apply_request(i_req_type, i_amount));
            accepted_cnt++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, occupancy", o_occupancy, -1);
            end else begin
                want = expected_q.pop_front();
                if (o_occupancy !== want.occupancy)
                    report_mismatch("occupancy", o_occupancy, want.occupancy);
                if (o_oldest_amount !== want.oldest_amount)
                    report_mismatch("oldest_amount", o_oldest_amount, want.oldest_amount);
                if (o_unserved !== want.unserved)
                    report_mismatch("unserved", o_unserved, want.unserved);
                if (o_dropped !== want.dropped)
                    report_mismatch("dropped", o_dropped, want.dropped);
            end
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                drv_loaded = 1'b0;
                drv_gap = drv_cur.idle ? $urandom_range(0, 4) : 0;
            end
            if (!drv_loaded) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pending_q.size() > 0 &&
                             (!pending_q[0].sync || expected_q.size() == 0)) begin
                    drv_cur = pending_q.pop_front();
                    drv_loaded = 1'b1;
                    sink_idle <= drv_cur.idle;
                end
            end
            i_valid <= drv_loaded;
            if (drv_loaded) begin
                i_req_type <= drv_cur.kind;
                i_amount <= drv_cur.amount;
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (out_taken)
            sink_wait = sink_idle ? $urandom_range(0, 4) : 0;
        i_stall <= hold_on || sink_wait > 0;
        if (o_valid && sink_wait > 0)
            sink_wait--;
    end

    // long receiver hold-off while the sender keeps going
    initial begin
        while (accepted_cnt < 400) @(posedge i_clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on = 1'b0;
    end

    initial begin
        int       ph;
        int       n;
        int       produce_pct;
        int       sel;
        logic     kind;
        logic [AW-1:0] amt;

        // directed: empty-queue consumes, zero entries, fill, drop on full, covers
        add_request(qfd_pkg::REQ_CONSUME, '0, 1'b0, 1'b0);
        add_request(qfd_pkg::REQ_CONSUME, '1, 1'b0, 1'b0);
        add_request(qfd_pkg::REQ_PRODUCE, '0, 1'b0, 1'b0);
        add_request(qfd_pkg::REQ_CONSUME, '0, 1'b0, 1'b0);
        add_request(qfd_pkg::REQ_PRODUCE, 16'd5, 1'b0, 1'b0);
        add_request(qfd_pkg::REQ_CONSUME, '0, 1'b0, 1'b0);
        add_request(qfd_pkg::REQ_PRODUCE, '1, 1'b0, 1'b0);
        add_request(qfd_pkg::REQ_PRODUCE, 16'h8000, 1'b0, 1'b0);
        add_request(qfd_pkg::REQ_PRODUCE, 16'hAAAA, 1'b0, 1'b0);
        add_request(qfd_pkg::REQ_PRODUCE, 16'h5555, 1'b0, 1'b0);
        for (n = 0; n < 11; n++)
            add_request(qfd_pkg::REQ_PRODUCE, AW'($urandom_range(1, 9)), 1'b0, 1'b1);
        add_request(qfd_pkg::REQ_PRODUCE, 16'h1234, 1'b0, 1'b0);
        add_request(qfd_pkg::REQ_CONSUME, 16'd3, 1'b0, 1'b0);
        add_request(qfd_pkg::REQ_CONSUME, 16'd2, 1'b0, 1'b0);
        add_request(qfd_pkg::REQ_CONSUME, '1, 1'b0, 1'b0);
        add_request(qfd_pkg::REQ_CONSUME, '1, 1'b0, 1'b0);

        // random phases: balanced, produce heavy, consume heavy
        for (ph = 0; ph < 7; ph++) begin
            case (ph % 3)
                0:       produce_pct = 50;
                1:       produce_pct = 75;
                default: produce_pct = 30;
            endcase
            for (n = 0; n < 150; n++) begin
                kind = ($urandom_range(0, 99) < produce_pct) ? qfd_pkg::REQ_PRODUCE
                                                             : qfd_pkg::REQ_CONSUME;
                sel = $urandom_range(0, 9);
                case (sel)
                    0:       amt = AW'($urandom_range(0, 16'hFFFF));
                    1:       amt = '0;
                    2:       amt = '1;
                    default: amt = (kind == qfd_pkg::REQ_PRODUCE) ?
                                   AW'($urandom_range(0, 40)) :
                                   AW'($urandom_range(0, 120));
                endcase
                add_request(kind, amt, n == 0, ph % 2 == 0);
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_q.size() > 0 || drv_loaded || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== quantity_fifo_drain.f =====
sv/qfd_pkg.sv
sv/qfd_ctrl.sv
sv/qfd_datapath.sv
sv/quantity_fifo_drain.sv
sv/qfd_checker.sv
dv/tb_quantity_fifo_drain.sv
